### hdl/rdr_pkg.sv
package rdr_pkg;

	// Coordinates are carried one bit wider than the 12-bit input fields so
	// that corner +/- 1 never wraps.
	localparam int unsigned IN_CW = 12;
	localparam int unsigned CW    = 13;
	localparam int unsigned PIX_W = 8;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [PIX_W-1:0] pixel_t;

	typedef enum logic [1:0] {
		ROP_COPY = 2'd0,
		ROP_XOR  = 2'd1,
		ROP_AND  = 2'd2,
		ROP_OR   = 2'd3
	} rop_t;

	typedef enum logic [1:0] {
		FUNC_RECT = 2'd0,
		FUNC_PLOT = 2'd1,
		FUNC_READ = 2'd2,
		FUNC_NOP  = 2'd3
	} func_t;

	localparam logic [1:0] STYLE_OUTLINE   = 2'd1;
	localparam logic [1:0] STYLE_FILL_ONLY = 2'd2;

	localparam logic [1:0] CFG_RASTER_MODE = 2'd0;
	localparam logic [1:0] CFG_LINE_COLOR  = 2'd1;
	localparam logic [1:0] CFG_FILL_COLOR  = 2'd2;

	localparam pixel_t RESET_COLOR = 8'd15;

	typedef enum logic [1:0] {
		PIX_CLEAR = 2'd0,
		PIX_RMW   = 2'd1,
		PIX_READ  = 2'd2
	} pix_op_t;

	// One pixel access handed to the frame store.
	typedef struct packed {
		logic    valid;
		pix_op_t op;
		pixel_t  color;
		rop_t    mode;
	} pix_req_t;

	typedef struct packed {
		logic   busy;
		logic   rd_valid;
		pixel_t rd_data;
	} pix_rsp_t;

	function automatic pixel_t rop_apply(input rop_t mode, input pixel_t src,
			input pixel_t dst);
		pixel_t res;
		unique case (mode)
			ROP_XOR: res = src ^ dst;
			ROP_AND: res = src & dst;
			ROP_OR:  res = src | dst;
			default: res = src;
		endcase
		return res;
	endfunction

endpackage

### hdl/rdr_frame_store.sv
module rdr_frame_store #(
	parameter int unsigned DEPTH = 64000,
	localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rdr_pkg::pix_req_t   req,
	input  logic [ADDR_W-1:0]   addr,
	output rdr_pkg::pix_rsp_t   rsp
);
	import rdr_pkg::*;

	pixel_t mem [DEPTH];

	logic              valid_s1;
	pix_op_t           op_s1;
	logic [ADDR_W-1:0] addr_s1;
	pixel_t            color_s1;
	rop_t              mode_s1;
	pixel_t            rdata_s1;

	logic              wr_valid_q;
	logic [ADDR_W-1:0] wr_addr_q;
	pixel_t            wr_data_q;

	logic              clr_we;
	logic              rmw_we;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	pixel_t            wdata;
	pixel_t            cur;

	// The read of an entry written in the same cycle returns the old value,
	// so the last write is forwarded.
	assign cur    = (wr_valid_q && wr_addr_q == addr_s1) ? wr_data_q : rdata_s1;
	assign clr_we = req.valid && req.op == PIX_CLEAR;
	assign rmw_we = valid_s1 && op_s1 == PIX_RMW;
	assign we     = clr_we || rmw_we;
	assign waddr  = rmw_we ? addr_s1 : addr;
	assign wdata  = rmw_we ? rop_apply(mode_s1, color_s1, cur) : req.color;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_s1 <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			op_s1      <= PIX_CLEAR;
			wr_valid_q <= 1'b0;
		end else begin
			valid_s1   <= req.valid && req.op != PIX_CLEAR;
			op_s1      <= req.op;
			wr_valid_q <= we;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= addr;
		color_s1  <= req.color;
		mode_s1   <= req.mode;
		wr_addr_q <= waddr;
		wr_data_q <= wdata;
	end

	assign rsp.busy     = valid_s1;
	assign rsp.rd_valid = valid_s1 && op_s1 == PIX_READ;
	assign rsp.rd_data  = cur;

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (32'(waddr) < DEPTH))
		else $error("frame store write beyond the last entry");

	a_clear_not_during_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		clr_we |-> !rmw_we)
		else $error("clear write collides with a read-modify-write");

	a_forward_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(rmw_we && $past(we) && $past(waddr) == addr_s1) |-> cur == $past(wdata))
		else $error("back-to-back access to one pixel missed the forwarded value");

endmodule

### hdl/rect_draw_raster_op_engine.sv
// Rectangle blitter with raster ops over an 8-bit indexed frame store.
//
// Commands arrive on the s_axis channel: s_axis_tuser carries the function
// (rectangle, plot, read) and s_axis_tdata the coordinates, the rectangle
// style and the plot color. Every command returns exactly one transaction on
// m_axis: the pixel of a read in m_axis_tdata (zero otherwise) and the
// on-screen flag in m_axis_tuser (both zero for a rectangle). The raster op
// and two colors are set through the cfg write port only while the engine
// is idle: a rule for the user that the block itself does not enforce.
// One command is worked at a time. Pixels are read, combined and written back
// at one per cycle through the frame memory: the interior column by column
// (unless outline only), then the top and bottom rows, then the side columns.
// Off-screen border pixels are still stepped through but are not written.
//
// After reset the frame memory is cleared one pixel per cycle, all
// SCREEN_WIDTH * SCREEN_HEIGHT entries (64000 by default); s_axis_tready stays
// low until then. The result sits in an output register, so a stalled
// receiver holds only the command after next: the next one is accepted and
// worked while the previous result still waits.
module rect_draw_raster_op_engine #(
	parameter int unsigned SCREEN_WIDTH  = 320,
	parameter int unsigned SCREEN_HEIGHT = 200
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// first_x[11:0], first_y[23:12], second_x[35:24], second_y[47:36],
	// rect_style[49:48], pixel_color[57:50], zero fill [63:58]
	input  logic [63:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// read_value[7:0]
	output logic [7:0]  m_axis_tdata,
	// in_bounds[0]
	output logic        m_axis_tuser,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import rdr_pkg::*;

	localparam int unsigned DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned XW     = $clog2(SCREEN_WIDTH);
	localparam int unsigned YW     = $clog2(SCREEN_HEIGHT);
	localparam coord_t      X_MAX  = coord_t'(SCREEN_WIDTH - 1);
	localparam coord_t      Y_MAX  = coord_t'(SCREEN_HEIGHT - 1);
	localparam coord_t      ONE    = coord_t'(1);
	localparam coord_t      ZERO   = coord_t'(0);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_FILL,
		ST_ROWS,
		ST_SIDES,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	rop_t              mode_q;
	pixel_t            line_color_q;
	pixel_t            fill_color_q;

	func_t             func_q;
	logic [1:0]        style_q;
	pixel_t            pcolor_q;
	coord_t            x1_q, y1_q, x2_q, y2_q;
	coord_t            cx_q, cy_q;
	logic              sub_q;
	logic              ib_q;
	pixel_t            rv_q;

	logic              m_valid_q;
	pixel_t            m_data_q;
	logic              m_user_q;

	// Input fields, sign-extended by one bit.
	coord_t in_fx, in_fy, in_sx, in_sy;
	assign in_fx = coord_t'(signed'(s_axis_tdata[11:0]));
	assign in_fy = coord_t'(signed'(s_axis_tdata[23:12]));
	assign in_sx = coord_t'(signed'(s_axis_tdata[35:24]));
	assign in_sy = coord_t'(signed'(s_axis_tdata[47:36]));

	logic s_acc;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = state_q == ST_IDLE;

	// Clipped spans. The interior and the side columns share the y span.
	coord_t fill_xlo, fill_xhi, in_ylo, in_yhi, row_xlo, row_xhi;
	logic   fill_ok, row_ok, side_ok;
	pixel_t border_color;

	assign fill_xlo = (x1_q + ONE > ZERO) ? x1_q + ONE : ZERO;
	assign fill_xhi = (x2_q - ONE < X_MAX) ? x2_q - ONE : X_MAX;
	assign in_ylo   = (y1_q + ONE > ZERO) ? y1_q + ONE : ZERO;
	assign in_yhi   = (y2_q - ONE < Y_MAX) ? y2_q - ONE : Y_MAX;
	assign row_xlo  = (x1_q > ZERO) ? x1_q : ZERO;
	assign row_xhi  = (x2_q < X_MAX) ? x2_q : X_MAX;
	assign fill_ok  = fill_xlo <= fill_xhi && in_ylo <= in_yhi;
	assign row_ok   = row_xlo <= row_xhi;
	assign side_ok  = in_ylo <= in_yhi;
	assign border_color = (style_q == STYLE_FILL_ONLY) ? fill_color_q : line_color_q;

	// Pixel issue toward the frame store.
	coord_t            iss_x, iss_y;
	logic              iss_want;
	logic              iss_on;
	pix_op_t           iss_op;
	pixel_t            iss_color;
	pix_req_t          req;
	pix_rsp_t          rsp;
	logic [ADDR_W-1:0] pix_addr;
	logic [ADDR_W-1:0] mem_addr;

	always_comb begin
		iss_x     = cx_q;
		iss_y     = cy_q;
		iss_want  = 1'b0;
		iss_op    = PIX_RMW;
		iss_color = border_color;
		unique case (state_q)
			ST_SETUP: begin
				iss_x     = x1_q;
				iss_y     = y1_q;
				iss_want  = func_q == FUNC_PLOT || func_q == FUNC_READ;
				iss_op    = (func_q == FUNC_READ) ? PIX_READ : PIX_RMW;
				iss_color = pcolor_q;
			end
			ST_FILL: begin
				iss_want  = fill_ok;
				iss_color = fill_color_q;
			end
			ST_ROWS: begin
				iss_y    = sub_q ? y2_q : y1_q;
				iss_want = row_ok;
			end
			ST_SIDES: begin
				iss_x    = sub_q ? x2_q : x1_q;
				iss_want = side_ok;
			end
			default: begin
			end
		endcase
	end

	assign iss_on = iss_x >= ZERO && iss_x <= X_MAX && iss_y >= ZERO && iss_y <= Y_MAX;
	assign pix_addr = ADDR_W'(iss_y[YW-1:0]) * ADDR_W'(SCREEN_WIDTH)
		+ ADDR_W'(iss_x[XW-1:0]);

	always_comb begin
		req.valid = iss_want && iss_on;
		req.op    = iss_op;
		req.color = iss_color;
		req.mode  = mode_q;
		mem_addr  = pix_addr;
		if (state_q == ST_CLEAR) begin
			req.valid = 1'b1;
			req.op    = PIX_CLEAR;
			req.color = '0;
			mem_addr  = clr_cnt_q;
		end
	end

	rdr_frame_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.addr   (mem_addr),
		.rsp    (rsp)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= ROP_COPY;
			line_color_q <= RESET_COLOR;
			fill_color_q <= RESET_COLOR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RASTER_MODE: mode_q       <= rop_t'(cfg_data[1:0]);
				CFG_LINE_COLOR:  line_color_q <= cfg_data;
				CFG_FILL_COLOR:  fill_color_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Command sequencer and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			m_valid_q <= 1'b0;
			func_q    <= FUNC_NOP;
			sub_q     <= 1'b0;
			ib_q      <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (rsp.rd_valid) begin
				rv_q <= rsp.rd_data;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
					if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_acc) begin
						func_q   <= func_t'(s_axis_tuser);
						style_q  <= s_axis_tdata[49:48];
						pcolor_q <= s_axis_tdata[57:50];
						if (func_t'(s_axis_tuser) == FUNC_RECT) begin
							x1_q <= (in_fx > in_sx) ? in_sx : in_fx;
							x2_q <= (in_fx > in_sx) ? in_fx : in_sx;
							y1_q <= (in_fy > in_sy) ? in_sy : in_fy;
							y2_q <= (in_fy > in_sy) ? in_fy : in_sy;
						end else begin
							x1_q <= in_fx;
							y1_q <= in_fy;
						end
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					ib_q  <= 1'b0;
					rv_q  <= '0;
					sub_q <= 1'b0;
					if (func_q == FUNC_RECT) begin
						if (style_q != STYLE_OUTLINE) begin
							cx_q    <= fill_xlo;
							cy_q    <= in_ylo;
							state_q <= ST_FILL;
						end else begin
							cx_q    <= row_xlo;
							state_q <= ST_ROWS;
						end
					end else begin
						ib_q    <= (func_q == FUNC_PLOT || func_q == FUNC_READ) && iss_on;
						state_q <= ST_DRAIN;
					end
				end
				ST_FILL: begin
					// Column by column, top to bottom inside each column.
					if (!fill_ok || (cx_q == fill_xhi && cy_q == in_yhi)) begin
						cx_q    <= row_xlo;
						sub_q   <= 1'b0;
						state_q <= ST_ROWS;
					end else if (cy_q == in_yhi) begin
						cy_q <= in_ylo;
						cx_q <= cx_q + ONE;
					end else begin
						cy_q <= cy_q + ONE;
					end
				end
				ST_ROWS: begin
					// Top then bottom pixel for each x, corners included.
					if (!row_ok || (cx_q == row_xhi && sub_q)) begin
						cy_q    <= in_ylo;
						sub_q   <= 1'b0;
						state_q <= ST_SIDES;
					end else if (sub_q) begin
						sub_q <= 1'b0;
						cx_q  <= cx_q + ONE;
					end else begin
						sub_q <= 1'b1;
					end
				end
				ST_SIDES: begin
					// Left then right pixel for each y strictly inside.
					if (!side_ok || (cy_q == in_yhi && sub_q)) begin
						state_q <= ST_DRAIN;
					end else if (sub_q) begin
						sub_q <= 1'b0;
						cy_q  <= cy_q + ONE;
					end else begin
						sub_q <= 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!rsp.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						m_data_q  <= rv_q;
						m_user_q  <= ib_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	a_one_command_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_axis_tready)
		else $error("second command accepted while one is in progress");

	a_offscreen_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata == '0)
		else $error("nonzero pixel value returned with an off-screen result");

	a_no_access_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> !req.valid)
		else $error("pixel access issued with no command in progress");

	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> !rsp.busy)
		else $error("result posted while a pixel access is still in flight");

endmodule
